// ===== sv/pwdd_pkg.sv =====
// ----------------------------------------------------------------------------
// pwdd_pkg
// Shared types, codes and helpers for the pulse-width downlink decoder.
// ----------------------------------------------------------------------------
package pwdd_pkg;

  // Default sizing
  localparam int FRAME_BYTES_DEF   = 14;
  localparam int PAYLOAD_BYTES_DEF = 10;
  localparam int COUNT_BITS_DEF    = 16;

  // Start edge plus two training edges come before the first data bit
  localparam int TRAIN_EDGES = 3;

  // Bit index carried in a command; covers the largest frame store
  localparam int BIT_IDX_W = 8;

  // Command queue depth
  localparam int CMD_DEPTH = 2;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOUT = 32'hFFFF_FFFF;

  // Received CRC value that is rejected besides zero
  localparam logic [31:0] RX_BAD_FF = 32'h0000_00FF;

  // Divide by ten as multiply by reciprocal, exact for 16-bit operands
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_EDGE    = 2'd0,
    STAT_ACCEPT  = 2'd1,
    STAT_REJECT  = 2'd2,
    STAT_NOFRAME = 2'd3
  } status_t;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_ABSORB  = 2'd0,
    CMD_SETBIT  = 2'd1,
    CMD_NOFRAME = 2'd2,
    CMD_CHECK   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [BIT_IDX_W-1:0]   bit_idx;
  } cmd_t;

  // One decoded result
  typedef struct packed {
    status_t     status;
    logic [7:0]  on_time_a;
    logic [15:0] cycles_a;
    logic [12:0] goal_a;
    logic [7:0]  on_time_b;
    logic [15:0] cycles_b;
    logic [12:0] goal_b;
  } result_t;

  // Advance the CRC over one byte, LSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== sv/pwdd_front.sv =====
// ----------------------------------------------------------------------------
// pwdd_front
// Accepts edge and timeout items, tracks edge skipping, training and bit
// position, and turns each item into one command for the back end.
// ----------------------------------------------------------------------------
module pwdd_front #(
  parameter int FRAME_BYTES = pwdd_pkg::FRAME_BYTES_DEF,
  parameter int COUNT_BITS  = pwdd_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_action,
  input  logic [15:0]   in_count,
  input  logic          q_full,
  output logic          q_push,
  output pwdd_pkg::cmd_t q_cmd
);
  import pwdd_pkg::*;

  localparam int BIT_LIMIT = FRAME_BYTES * 8 + TRAIN_EDGES;
  localparam int BP_W      = $clog2(BIT_LIMIT + 1);

  logic                  skip_r, skip_nxt;
  logic [BP_W-1:0]       bp_r, bp_nxt;
  logic [COUNT_BITS-1:0] first_r, first_nxt;
  logic [COUNT_BITS-1:0] cutoff_r, cutoff_nxt;
  logic [COUNT_BITS-1:0] width_w;
  logic [COUNT_BITS:0]   train_sum;
  logic [BP_W-1:0]       bit_k;
  cmd_t                  cmd_w;

  // Mask the timer count to the counter width
  assign width_w   = COUNT_BITS'(in_count);
  assign train_sum = {1'b0, first_r} + {1'b0, width_w};
  assign bit_k     = bp_r - BP_W'(TRAIN_EDGES);

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_cmd    = cmd_w;

  // Classify the item and work out the next front state
  always_comb begin
    skip_nxt       = skip_r;
    bp_nxt         = bp_r;
    first_nxt      = first_r;
    cutoff_nxt     = cutoff_r;
    cmd_w.kind     = CMD_ABSORB;
    // flip low bits so data bits land MSB first within each byte
    cmd_w.bit_idx  = BIT_IDX_W'(bit_k) ^ BIT_IDX_W'(7);
    if (!in_action) begin
      if (skip_r) begin
        skip_nxt = 1'b0;
      end else begin
        skip_nxt = 1'b1;
        if (bp_r == BP_W'(1)) begin
          first_nxt = width_w;
        end else if (bp_r == BP_W'(2)) begin
          cutoff_nxt = train_sum[COUNT_BITS:1];
        end else if (bp_r >= BP_W'(TRAIN_EDGES) && bp_r < BP_W'(BIT_LIMIT)) begin
          if (width_w > cutoff_r) begin
            cmd_w.kind = CMD_SETBIT;
          end
        end
        if (bp_r < BP_W'(BIT_LIMIT)) begin
          bp_nxt = bp_r + BP_W'(1);
        end
      end
    end else begin
      if (bp_r == '0) begin
        cmd_w.kind = CMD_NOFRAME;
      end else begin
        cmd_w.kind = CMD_CHECK;
        bp_nxt     = '0;
      end
    end
  end

  // Update front state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r   <= 1'b0;
      bp_r     <= '0;
      first_r  <= '0;
      cutoff_r <= '0;
    end else if (q_push) begin
      skip_r   <= skip_nxt;
      bp_r     <= bp_nxt;
      first_r  <= first_nxt;
      cutoff_r <= cutoff_nxt;
    end
  end

endmodule

// ===== sv/pwdd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// pwdd_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pwdd_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pwdd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pwdd_pkg::cmd_t pop_cmd
);
  import pwdd_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);

  cmd_t               entry_r [CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     count_r;

  assign full      = (count_r == (PTR_W + 1)'(CMD_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/pwdd_back.sv =====
// ----------------------------------------------------------------------------
// pwdd_back
// Carries out queued commands: sets frame bits, runs the CRC-32 frame check
// one byte per cycle, decodes the well fields and holds the result register.
// ----------------------------------------------------------------------------
module pwdd_back #(
  parameter int FRAME_BYTES   = pwdd_pkg::FRAME_BYTES_DEF,
  parameter int PAYLOAD_BYTES = pwdd_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  pwdd_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output pwdd_pkg::result_t out_res
);
  import pwdd_pkg::*;

  localparam int FRAME_BITS = FRAME_BYTES * 8;
  localparam int SIDX_W     = $clog2(FRAME_BITS);
  localparam int EXT_A      = (PAYLOAD_BYTES + 4 > 10) ? PAYLOAD_BYTES + 4 : 10;
  localparam int EXT_BYTES  = (FRAME_BYTES > EXT_A) ? FRAME_BYTES : EXT_A;
  localparam int EXT_BITS   = EXT_BYTES * 8;
  localparam int IDX_W      = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int RX_LO      = PAYLOAD_BYTES * 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CRC,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [FRAME_BITS-1:0] store_r;
  logic [31:0]         crc_r;
  logic [IDX_W-1:0]    crc_idx_r;
  logic                out_valid_r;
  result_t             out_res_r;

  logic [EXT_BITS-1:0] frame_ext;
  logic [7:0]          crc_data;
  logic [31:0]         rx_crc;
  logic [31:0]         calc_crc;
  logic                frame_ok;
  logic [15:0]         goal_raw_a, goal_raw_b;
  logic [32:0]         goal_prod_a, goal_prod_b;
  logic                out_free;
  result_t             final_res;
  logic                out_load;
  result_t             out_res_nxt;

  // Bytes past the store read as zero; byte 0 sits in the low bits
  assign frame_ext = EXT_BITS'(store_r);
  assign crc_data  = frame_ext[{crc_idx_r, 3'b000} +: 8];

  // Received CRC is big-endian after the payload
  assign rx_crc   = {frame_ext[RX_LO +: 8], frame_ext[RX_LO + 8 +: 8],
                     frame_ext[RX_LO + 16 +: 8], frame_ext[RX_LO + 24 +: 8]};
  assign calc_crc = crc_r ^ CRC_XOUT;
  assign frame_ok = (calc_crc == rx_crc) && (rx_crc != '0) && (rx_crc != RX_BAD_FF);

  // Goals divided by ten through the reciprocal
  assign goal_raw_a  = {frame_ext[24 +: 8], frame_ext[32 +: 8]};
  assign goal_raw_b  = {frame_ext[64 +: 8], frame_ext[72 +: 8]};
  assign goal_prod_a = {17'd0, goal_raw_a} * {16'd0, DIV10_MUL};
  assign goal_prod_b = {17'd0, goal_raw_b} * {16'd0, DIV10_MUL};

  // Assemble the frame check result
  always_comb begin
    final_res = '0;
    if (frame_ok) begin
      final_res.status    = STAT_ACCEPT;
      final_res.on_time_a = frame_ext[0 +: 8];
      final_res.cycles_a  = {frame_ext[8 +: 8], frame_ext[16 +: 8]};
      final_res.goal_a    = goal_prod_a[DIV10_SHIFT +: 13];
      final_res.on_time_b = frame_ext[40 +: 8];
      final_res.cycles_b  = {frame_ext[48 +: 8], frame_ext[56 +: 8]};
      final_res.goal_b    = goal_prod_b[DIV10_SHIFT +: 13];
    end else begin
      final_res.status    = STAT_REJECT;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Pop a command when it can be finished or a check can start
  always_comb begin
    cmd_pop = 1'b0;
    if (state_r == S_IDLE && cmd_valid) begin
      cmd_pop = (cmd.kind == CMD_CHECK) ? 1'b1 : out_free;
    end
  end

  // Pick the result that enters the output register this cycle
  always_comb begin
    out_load    = 1'b0;
    out_res_nxt = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_pop && cmd.kind != CMD_CHECK) begin
          out_load           = 1'b1;
          out_res_nxt.status = (cmd.kind == CMD_NOFRAME) ? STAT_NOFRAME : STAT_EDGE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_res_nxt = final_res;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Back end sequencer, store and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      store_r     <= '0;
      out_valid_r <= 1'b0;
      crc_r       <= CRC_INIT;
      crc_idx_r   <= '0;
    end else begin
      // Load a new result or drop the one just taken
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_res_r   <= out_res_nxt;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.kind)
              CMD_CHECK: begin
                crc_r     <= CRC_INIT;
                crc_idx_r <= '0;
                state_r   <= S_CRC;
              end
              CMD_SETBIT: begin
                store_r[cmd.bit_idx[SIDX_W-1:0]] <= 1'b1;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_CRC: begin
          crc_r     <= crc32_byte(crc_r, crc_data);
          crc_idx_r <= crc_idx_r + IDX_W'(1);
          if (crc_idx_r == IDX_W'(PAYLOAD_BYTES - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            store_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/pulse_width_downlink_decoder_core.sv =====
// ----------------------------------------------------------------------------
// pulse_width_downlink_decoder_core
// Pulse-width downlink decoder with CRC-32 frame check, stream interface.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one result transfer, in order. The
// front end takes an item whenever its two-entry command queue has room,
// so edges stream in back to back. In the back end an edge, or a timeout
// with no open frame, writes its result straight into the output register;
// a frame check runs the CRC-32 unit, which folds in one payload byte per
// cycle, and then compares the CRC and divides the goal fields by ten.
// Results wait in an output register, so the back end keeps working until
// that register is occupied and not taken.
// ----------------------------------------------------------------------------
module pulse_width_downlink_decoder_core #(
  parameter int FRAME_BYTES   = pwdd_pkg::FRAME_BYTES_DEF,
  parameter int PAYLOAD_BYTES = pwdd_pkg::PAYLOAD_BYTES_DEF,
  parameter int COUNT_BITS    = pwdd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] elapsed_count
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] on_time_a, [23:8] cycles_a,
                                  // [36:24] goal_a, [44:37] on_time_b,
                                  // [60:45] cycles_b, [73:61] goal_b,
                                  // [79:74] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import pwdd_pkg::*;

  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_not_empty;
  result_t res;

  pwdd_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_count  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  pwdd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (pop_cmd)
  );

  pwdd_back #(
    .FRAME_BYTES   (FRAME_BYTES),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (pop_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result fields onto the stream
  assign out_tuser = res.status;
  assign out_tdata = {6'd0, res.goal_b, res.cycles_b, res.on_time_b,
                      res.goal_a, res.cycles_a, res.on_time_a};

endmodule

// ===== sv/pwdd_checker.sv =====
// ----------------------------------------------------------------------------
// pwdd_checker
// Port-level checks for the pulse-width downlink decoder, bound to the top.
// ----------------------------------------------------------------------------
module pwdd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import pwdd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Drop any pending result on reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

  // Data fields are zero unless the frame was accepted
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_ACCEPT) |-> out_tdata == '0)
    else $error("data fields set on a non-accepted result");

  // Goals are a 16-bit value divided by ten
  a_goal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_ACCEPT) |->
      (out_tdata[36:24] <= 13'd6553) && (out_tdata[73:61] <= 13'd6553))
    else $error("goal out of range");

endmodule

bind pulse_width_downlink_decoder_core pwdd_checker u_pwdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/pulse_width_downlink_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// pulse_width_downlink_decoder_core_test
// Self-checking bench for the pulse-width downlink decoder. Stream transfers
// go in with random gaps and come out under random back-pressure. A local
// decode model predicts every result: edge skipping, training and cutoff,
// bit packing with saturation, and the CRC-32 frame check. Frames are built
// with a proper CRC, a CRC of zero or 0xFF, a flipped bit, or cut short.
// ----------------------------------------------------------------------------
module pulse_width_downlink_decoder_core_test;
  import pwdd_pkg::*;

  localparam int FB          = FRAME_BYTES_DEF;
  localparam int PB          = PAYLOAD_BYTES_DEF;
  localparam int DATA_BITS   = FB * 8;
  localparam int BIT_LIMIT   = DATA_BITS + TRAIN_EDGES;
  localparam int RANDOM_ITEMS = 1600;
  localparam int STALL_CYCLES = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4 * (PB + 2);

  localparam logic ACT_EDGE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] RX_ZERO    = 32'h0000_0000;
  localparam logic [31:0] RX_FF      = 32'h0000_00FF;

  typedef logic [DATA_BITS-1:0] frame_vec_t;  // byte i at [8*i +: 8]

  typedef enum int {
    FRAME_GOOD,
    FRAME_EXTREME,
    FRAME_CRC_ZERO,
    FRAME_CRC_FF,
    FRAME_CORRUPT,
    FRAME_SHORT,
    FRAME_KIND_COUNT
  } frame_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [15:0] elapsed_count
  logic        in_tuser;    // [0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;   // [7:0] on_time_a, [23:8] cycles_a, [36:24] goal_a,
                            // [44:37] on_time_b, [60:45] cycles_b,
                            // [73:61] goal_b, [79:74] zero
  logic [1:0]  out_tuser;   // [1:0] status

  // Decode model state
  logic        edge_skip = 1'b0;
  int          bit_index = 0;
  logic [15:0] train_a   = '0;
  logic [15:0] train_b   = '0;
  logic [15:0] threshold = '0;
  frame_vec_t  rx_store  = '0;

  result_t decoded_results[$];
  int      errors        = 0;
  int      items_sent    = 0;
  int      quiet_cycles  = 0;
  logic    steady        = 1'b0;
  int      hold_request  = 0;

  pulse_width_downlink_decoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run the CRC register over the first n bytes, no final inversion
  function automatic logic [31:0] crc_run(input frame_vec_t f, input int n);
    logic [31:0] crc;
    crc = CRC32_INIT;
    for (int i = 0; i < n; i++) begin
      crc ^= {24'd0, f[i*8 +: 8]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC32_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  function automatic logic [15:0] be16(input frame_vec_t f, input int idx);
    return {f[idx*8 +: 8], f[(idx+1)*8 +: 8]};
  endfunction

  // Predict the result of one accepted item and advance the model
  function automatic result_t decode_item(input logic act, input logic [15:0] cnt);
    result_t     res;
    logic [31:0] calc;
    logic [31:0] rx;
    logic [16:0] sum;
    logic [15:0] word;
    int          k;
    res = '0;
    res.status = STAT_EDGE;
    if (act == ACT_EDGE) begin
      // swallow every other edge
      if (edge_skip) begin
        edge_skip = 1'b0;
        return res;
      end
      edge_skip = 1'b1;
      if (bit_index == 1) begin
        train_a = cnt;
      end else if (bit_index == 2) begin
        train_b = cnt;
        sum = {1'b0, train_a} + {1'b0, train_b};
        threshold = sum[16:1];
      end else if (bit_index >= TRAIN_EDGES && bit_index < BIT_LIMIT) begin
        k = bit_index - TRAIN_EDGES;
        if (cnt > threshold) rx_store[(k >> 3) * 8 + 7 - (k & 7)] = 1'b1;
      end
      if (bit_index < BIT_LIMIT) bit_index++;
      return res;
    end
    if (bit_index == 0) begin
      res.status = STAT_NOFRAME;
      return res;
    end
    bit_index = 0;
    calc = crc_run(rx_store, PB) ^ CRC32_INIT;
    rx = {rx_store[PB*8 +: 8], rx_store[(PB+1)*8 +: 8],
          rx_store[(PB+2)*8 +: 8], rx_store[(PB+3)*8 +: 8]};
    if (calc != rx || rx == RX_ZERO || rx == RX_FF) begin
      res.status = STAT_REJECT;
    end else begin
      res.status    = STAT_ACCEPT;
      res.on_time_a = rx_store[7:0];
      res.cycles_a  = be16(rx_store, 1);
      word          = be16(rx_store, 3) / 16'd10;
      res.goal_a    = word[12:0];
      res.on_time_b = rx_store[5*8 +: 8];
      res.cycles_b  = be16(rx_store, 6);
      word          = be16(rx_store, 8) / 16'd10;
      res.goal_b    = word[12:0];
    end
    rx_store = '0;
    return res;
  endfunction

  // Offer one item after a random gap; hold tvalid when no gap is drawn
  task automatic send_item(input logic act, input logic [15:0] cnt);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= cnt;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decoded_results.push_back(decode_item(act, cnt));
    items_sent++;
  endtask

  // Send an edge that is counted, inserting a swallowed one when needed
  task automatic send_used_edge(input logic [15:0] cnt);
    if (edge_skip) send_item(ACT_EDGE, 16'($urandom_range(0, 16'hFFFF)));
    send_item(ACT_EDGE, cnt);
  endtask

  // Pick a width that decodes to the given bit under the current cutoff
  function automatic logic [15:0] width_for(input logic b);
    int lo;
    lo = int'(threshold);
    if (b && threshold != 16'hFFFF) return 16'($urandom_range(lo + 1, 16'hFFFF));
    return 16'($urandom_range(0, lo));
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (decoded_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d data %0h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = decoded_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_tuser));
        check_field("on_time_a", 16'(want.on_time_a), 16'(out_tdata[7:0]));
        check_field("cycles_a", want.cycles_a, out_tdata[23:8]);
        check_field("goal_a", 16'(want.goal_a), 16'(out_tdata[36:24]));
        check_field("on_time_b", 16'(want.on_time_b), 16'(out_tdata[44:37]));
        check_field("cycles_b", want.cycles_b, out_tdata[60:45]);
        check_field("goal_b", 16'(want.goal_b), 16'(out_tdata[73:61]));
        check_field("pad", '0, 16'(out_tdata[79:74]));
      end
    end
  end

  // Drop out when no transfer moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, decoded_results.size());
        $display("pulse_width_downlink_decoder_core_test: done, errors");
        $finish;
      end
    end
  end

  // Result receiver: random stall before each transfer, long hold on request
  initial begin : receiver
    int pause;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        pause = hold_request;
        hold_request = 0;
      end else begin
        pause = steady ? 0 : $urandom_range(0, 7);
      end
      if (pause > 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Build a frame of the given kind and send it edge by edge
  task automatic run_frame(input frame_kind_t kind);
    frame_vec_t  f;
    logic [31:0] crc;
    logic [31:0] target;
    logic        top;
    logic [7:0]  fill;
    logic [15:0] w1;
    logic [15:0] w2;
    int          nbits;
    int          extra;
    f     = '0;
    fill  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    w1    = 16'($urandom_range(0, 16'hFFFF));
    w2    = 16'($urandom_range(0, 16'hFFFF));
    nbits = DATA_BITS;
    extra = $urandom_range(0, 1) ? $urandom_range(1, 4) : 0;
    for (int i = 0; i < PB; i++) begin
      f[i*8 +: 8] = (kind == FRAME_EXTREME) ? fill : 8'($urandom);
    end
    if (kind == FRAME_EXTREME) begin
      w1 = '0;
      w2 = '0;
    end
    // force the payload CRC by solving for payload bytes 6..9
    if (kind == FRAME_CRC_ZERO || kind == FRAME_CRC_FF) begin
      target = ((kind == FRAME_CRC_ZERO) ? RX_ZERO : RX_FF) ^ CRC32_INIT;
      for (int i = 0; i < 32; i++) begin
        top = target[31];
        target = top ? (((target ^ CRC32_POLY) << 1) | 32'd1) : (target << 1);
      end
      f[6*8 +: 32] = crc_run(f, 6) ^ target;
    end
    crc = crc_run(f, PB) ^ CRC32_INIT;
    for (int i = 0; i < 4; i++) f[(PB+i)*8 +: 8] = crc[31-8*i -: 8];
    if (kind == FRAME_CORRUPT) f[$urandom_range(0, DATA_BITS-1)] ^= 1'b1;
    if (kind == FRAME_SHORT) begin
      nbits = $urandom_range(0, DATA_BITS-1);
      extra = 0;
    end

    // close any frame left open by earlier noise
    if (bit_index != 0) send_item(ACT_TIMEOUT, 16'($urandom_range(0, 16'hFFFF)));
    send_used_edge(16'($urandom_range(0, 16'hFFFF)));
    send_used_edge(w1);
    send_used_edge(w2);
    for (int k = 0; k < nbits; k++) begin
      send_used_edge(width_for(f[(k >> 3) * 8 + 7 - (k & 7)]));
    end
    repeat (extra) send_used_edge(16'($urandom_range(0, 16'hFFFF)));
    send_item(ACT_TIMEOUT, 16'($urandom_range(0, 16'hFFFF)));
  endtask

  // Timeouts with no frame open, count extremes
  task automatic test_idle_timeouts();
    send_item(ACT_TIMEOUT, 16'h0000);
    send_item(ACT_TIMEOUT, 16'hFFFF);
  endtask

  // Short frames: extreme training widths, swallowed edges, rejects
  task automatic test_short_frames();
    // cutoff zero: width 0 gives 0, anything above gives 1
    send_used_edge(16'h0000);
    send_used_edge(16'h0000);
    send_used_edge(16'h0000);
    send_used_edge(16'h0000);
    send_used_edge(16'h0001);
    send_used_edge(16'hFFFF);
    send_item(ACT_TIMEOUT, 16'hFFFF);
    send_item(ACT_TIMEOUT, 16'h0000);
    // the toggle survives the timeouts, so this edge is swallowed
    send_item(ACT_EDGE, 16'hFFFF);
    // cutoff at full scale: even the widest pulse reads as 0
    send_used_edge(16'hFFFF);
    send_used_edge(16'hFFFF);
    send_used_edge(16'hFFFF);
    send_used_edge(16'hFFFF);
    send_used_edge(16'h8000);
    send_item(ACT_TIMEOUT, 16'h5555);
  endtask

  // Hold the output for a long stretch while edges keep coming
  task automatic test_output_stall();
    steady = 1'b1;
    hold_request = STALL_CYCLES;
    repeat (24) begin
      send_item(($urandom_range(0, 5) == 0) ? ACT_TIMEOUT : ACT_EDGE,
                16'($urandom_range(0, 16'hFFFF)));
    end
    steady = 1'b0;
  endtask

  // Mostly well-formed frames, every kind at least once, mixed with noise
  task automatic test_random_traffic();
    int          frames;
    int          start;
    int          pick;
    frame_kind_t kind;
    frames = 0;
    start  = items_sent;
    while (items_sent - start < RANDOM_ITEMS || frames < FRAME_KIND_COUNT) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        if (frames < FRAME_KIND_COUNT) begin
          kind = frame_kind_t'(frames);
        end else begin
          pick = $urandom_range(0, 9);
          case (pick)
            5:       kind = FRAME_EXTREME;
            6:       kind = FRAME_CRC_ZERO;
            7:       kind = FRAME_CRC_FF;
            8:       kind = FRAME_CORRUPT;
            9:       kind = FRAME_SHORT;
            default: kind = FRAME_GOOD;
          endcase
        end
        run_frame(kind);
        frames++;
      end else begin
        repeat ($urandom_range(5, 20)) begin
          send_item(($urandom_range(0, 3) == 0) ? ACT_TIMEOUT : ACT_EDGE,
                    16'($urandom_range(0, 16'hFFFF)));
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_EDGE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_timeouts();
    test_short_frames();
    test_output_stall();
    test_random_traffic();

    // drain, then watch for stray results
    in_tvalid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("pulse_width_downlink_decoder_core_test: done, clean");
    end else begin
      $display("pulse_width_downlink_decoder_core_test: done, errors");
    end
    $finish;
  end

endmodule
